>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, suspended while reset is asserted.
`define GCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never hold outside reset.
`define GCS_NEVER(label, cond, msg) \
	`GCS_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/gcs_pkg.sv
`timescale 1ns / 1ps
package gcs_pkg;

	localparam int unsigned CoeffDepthDef  = 1024;
	localparam int unsigned MaxFeaturesDef = 64;

	localparam logic [1:0] CMD_COEFF  = 2'd0;
	localparam logic [1:0] CMD_OFFSET = 2'd1;
	localparam logic [1:0] CMD_LEVEL  = 2'd2;

	localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
	localparam logic [63:0] ROOT64_Q30 = 64'd1085434106;
	localparam logic [47:0] PRED_MAX   = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OFF,
		S_ADD,
		S_ICPT,
		S_EXP,
		S_EMIT
	} state_t;

	// Q30 values of 2^(k/64) for k = 0..64.
	typedef logic [31:0] etab_t [0:64];

	function automatic etab_t make_etab();
		etab_t       tab;
		logic [63:0] e;
		e = 64'd1 << 30;
		for (int k = 0; k <= 64; k++) begin
			tab[k] = e[31:0];
			e = (e * ROOT64_Q30 + (64'd1 << 29)) >> 30;
		end
		return tab;
	endfunction

	localparam etab_t E_TAB = make_etab();

endpackage

>>> hw/rtl/glm_categorical_score_top.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid/in_ready     cmd feature level coeff_index coeff_value offset_value
//                                 weight response sample_id last
// result    out_valid/out_ready   obs_number sample_out response_out linear_predictor
//                                 prediction weight_out index_error
// config    cfg_we                cfg_wdata (feature_mask)
//
// Table writes (cmd 0 and 1) and unused commands are taken in the idle state, which they do not leave.
// A level item passes through offset read, coefficient read and accumulate in turn;
// each table has a single read port.
// A level item marked last adds the intercept read and the four-stage exponent
// pipeline; the result then goes to the output register once that is empty or being taken.
// Reset clears the accumulator, error flag, counter and mask; tables are not cleared.
// A waiting result does not block new items until the next result is ready.
module glm_categorical_score_top #(
	parameter int unsigned COEFF_DEPTH  = gcs_pkg::CoeffDepthDef,
	parameter int unsigned MAX_FEATURES = gcs_pkg::MaxFeaturesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [5:0]         feature,
	input  logic [7:0]         level,
	input  logic [9:0]         coeff_index,
	input  logic signed [23:0] coeff_value,
	input  logic [9:0]         offset_value,
	input  logic [31:0]        weight,
	input  logic signed [31:0] response,
	input  logic [23:0]        sample_id,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        obs_number,
	output logic [23:0]        sample_out,
	output logic signed [31:0] response_out,
	output logic signed [31:0] linear_predictor,
	output logic [47:0]        prediction,
	output logic [31:0]        weight_out,
	output logic               index_error
);
	import gcs_pkg::*;

	`include "assert_macros.svh"

	localparam int unsigned CW = $clog2(COEFF_DEPTH);
	localparam int unsigned FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam logic signed [40:0] ACC_MAX = 41'sh0_7F_FFFF_FFFF;
	localparam logic signed [40:0] ACC_MIN = -41'sh0_80_0000_0000;
	localparam logic signed [40:0] LP_MAX  = 41'sh0_00_7FFF_FFFF;
	localparam logic signed [40:0] LP_MIN  = -41'sh0_00_8000_0000;

	state_t state_q, state_d;

	logic [63:0]        mask_q;
	logic signed [39:0] acc_q;
	logic               err_q;
	logic [31:0]        obs_q;
	logic [7:0]         level_q;
	logic               en_q, last_q, add_q;
	logic [31:0]        weight_q;
	logic signed [31:0] resp_q;
	logic [23:0]        sample_q;
	logic signed [31:0] lp_q;
	logic [47:0]        pred_q;

	logic               accept;
	logic               feat_ok;
	logic [23:0]        coeff_rdata;
	logic [9:0]         off_rdata;
	logic [10:0]        k;
	logic               k_ok;
	logic [CW-1:0]      coeff_raddr;
	logic signed [40:0] acc_sum;
	logic signed [40:0] lp_sum;
	logic signed [31:0] lp;
	logic               exp_start;
	logic               exp_done;
	logic [47:0]        exp_pred;
	logic               emit;

	assign accept  = in_valid && in_ready;
	assign feat_ok = 32'(feature) < MAX_FEATURES;

	// Coefficient address is the feature offset plus the level; out of range is an error for an enabled feature.
	assign k           = 11'(off_rdata) + 11'(level_q);
	assign k_ok        = 32'(k) < COEFF_DEPTH;
	assign coeff_raddr = (state_q == S_OFF && k_ok) ? CW'(k) : '0;

	assign acc_sum = 41'(acc_q) + 41'(signed'(coeff_rdata));
	assign lp_sum  = 41'(signed'(coeff_rdata)) + 41'(acc_q);
	assign lp      = (lp_sum > LP_MAX) ? 32'sh7FFF_FFFF :
	                 (lp_sum < LP_MIN) ? 32'sh8000_0000 : lp_sum[31:0];

	assign exp_start = (state_q == S_ICPT);
	assign emit      = (state_q == S_EMIT) && (!out_valid || out_ready);

	gcs_tables #(
		.COEFF_DEPTH (COEFF_DEPTH),
		.MAX_FEATURES(MAX_FEATURES),
		.CW          (CW),
		.FW          (FW)
	) u_tables (
		.clk        (clk),
		.coeff_we   (accept && cmd == CMD_COEFF && 32'(coeff_index) < COEFF_DEPTH),
		.coeff_waddr(CW'(coeff_index)),
		.coeff_wdata(coeff_value),
		.coeff_raddr(coeff_raddr),
		.coeff_rdata(coeff_rdata),
		.off_we     (accept && cmd == CMD_OFFSET && feat_ok),
		.off_waddr  (FW'(feature)),
		.off_wdata  (offset_value),
		.off_raddr  (FW'(feature)),
		.off_rdata  (off_rdata)
	);

	gcs_exp u_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (exp_start),
		.lp    (lp),
		.weight(weight_q),
		.done  (exp_done),
		.pred  (exp_pred)
	);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && cmd == CMD_LEVEL) begin
					state_d = S_OFF;
				end
			end
			S_OFF:  state_d = S_ADD;
			S_ADD:  state_d = last_q ? S_ICPT : S_IDLE;
			S_ICPT: state_d = S_EXP;
			S_EXP: begin
				if (exp_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mask_q    <= '0;
			acc_q     <= '0;
			err_q     <= 1'b0;
			obs_q     <= '0;
			out_valid <= 1'b0;
			en_q      <= 1'b0;
			last_q    <= 1'b0;
			add_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (accept && cmd == CMD_LEVEL) begin
				en_q   <= feat_ok && mask_q[feature];
				last_q <= last;
			end
			if (state_q == S_OFF) begin
				add_q <= en_q && k_ok;
				if (en_q && !k_ok) begin
					err_q <= 1'b1;
				end
			end
			if (state_q == S_ADD && add_q) begin
				acc_q <= (acc_sum > ACC_MAX) ? ACC_MAX[39:0] :
				         (acc_sum < ACC_MIN) ? ACC_MIN[39:0] : acc_sum[39:0];
			end
			if (emit) begin
				out_valid <= 1'b1;
				obs_q     <= obs_q + 32'd1;
				acc_q     <= '0;
				err_q     <= 1'b0;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Item payload and result registers.
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_LEVEL) begin
			level_q  <= level;
			weight_q <= weight;
			resp_q   <= response;
			sample_q <= sample_id;
		end
		if (exp_start) begin
			lp_q <= lp;
		end
		if (state_q == S_EXP && exp_done) begin
			pred_q <= exp_pred;
		end
		if (emit) begin
			obs_number       <= obs_q;
			sample_out       <= sample_q;
			response_out     <= resp_q;
			linear_predictor <= lp_q;
			prediction       <= pred_q;
			weight_out       <= weight_q;
			index_error      <= err_q;
		end
	end

	`GCS_ASSERT(a_emit_valid, emit |=> out_valid, "result not presented after emit")
	`GCS_ASSERT(a_obs_step, emit |=> obs_q == $past(obs_q) + 32'd1, "counter did not step")
	`GCS_NEVER(a_exp_stray, exp_done && state_q != S_EXP, "exp result outside wait state")

endmodule

>>> hw/rtl/gcs_tables.sv
`timescale 1ns / 1ps
module gcs_tables #(
	parameter int unsigned COEFF_DEPTH  = gcs_pkg::CoeffDepthDef,
	parameter int unsigned MAX_FEATURES = gcs_pkg::MaxFeaturesDef,
	parameter int unsigned CW = $clog2(COEFF_DEPTH),
	parameter int unsigned FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic          clk,
	input  logic          coeff_we,
	input  logic [CW-1:0] coeff_waddr,
	input  logic [23:0]   coeff_wdata,
	input  logic [CW-1:0] coeff_raddr,
	output logic [23:0]   coeff_rdata,
	input  logic          off_we,
	input  logic [FW-1:0] off_waddr,
	input  logic [9:0]    off_wdata,
	input  logic [FW-1:0] off_raddr,
	output logic [9:0]    off_rdata
);
	import gcs_pkg::*;

	logic [23:0] coeff_mem [COEFF_DEPTH];
	logic [9:0]  off_mem [MAX_FEATURES];

	always_ff @(posedge clk) begin
		if (coeff_we) begin
			coeff_mem[coeff_waddr] <= coeff_wdata;
		end
		coeff_rdata <= coeff_mem[coeff_raddr];
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_waddr] <= off_wdata;
		end
		off_rdata <= off_mem[off_raddr];
	end

endmodule

>>> hw/rtl/gcs_exp.sv
`timescale 1ns / 1ps
module gcs_exp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] lp,
	input  logic [31:0]        weight,
	output logic               done,
	output logic [47:0]        pred
);
	import gcs_pkg::*;

	`include "assert_macros.svh"

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [62:0] prod_s1;
	logic [31:0]        w_s1, w_s2;
	logic signed [16:0] n_s2, n_s3;
	logic [31:0]        m_s2;
	logic [63:0]        p_s3;
	logic [47:0]        res_s4;

	logic signed [32:0] t;
	logic [5:0]         idx;
	logic [9:0]         frac;
	logic [31:0]        e0, e1, diff;
	logic [41:0]        interp;
	logic signed [17:0] s;
	logic [5:0]         sh;
	logic [63:0]        q;
	logic [47:0]        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Interpolated fraction of the power of two.
	always_comb begin
		t      = 33'(prod_s1 >>> 30);
		idx    = t[15:10];
		frac   = t[9:0];
		e0     = E_TAB[idx];
		e1     = E_TAB[7'(idx) + 7'd1];
		diff   = e1 - e0;
		interp = (42'(diff) * 42'(frac) + 42'd512) >> 10;
	end

	// Scale by 2^(n-30) and saturate.
	always_comb begin
		s   = 18'(n_s3) - 18'sd30;
		sh  = s[5:0];
		q   = '0;
		res = '0;
		if (p_s3 == '0) begin
			res = '0;
		end else if (s >= 0) begin
			if (s >= 18'sd48) begin
				res = PRED_MAX;
			end else if ((p_s3 >> (7'd48 - 7'(sh))) != '0) begin
				res = PRED_MAX;
			end else begin
				res = 48'(p_s3 << sh);
			end
		end else if (s <= -18'sd64) begin
			res = '0;
		end else begin
			q   = p_s3 >> 6'(-s);
			res = (q[63:48] != '0) ? PRED_MAX : q[47:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 63'(lp) * 63'(signed'({1'b0, LOG2E_Q30}));
		w_s1    <= weight;
		n_s2    <= t[32:16];
		m_s2    <= e0 + interp[31:0];
		w_s2    <= w_s1;
		n_s3    <= n_s2;
		p_s3    <= 64'(m_s2) * 64'(w_s2);
		res_s4  <= res;
	end

	assign done = v_s4;
	assign pred = res_s4;

	`GCS_ASSERT(a_exp_latency, v_s4 |-> $past(start, 4), "exp result without a start")
	`GCS_NEVER(a_exp_overlap, start && (v_s1 || v_s2 || v_s3), "exp start while busy")

endmodule

>>> verif/tb_glm_categorical_score_top.sv
`timescale 1ns / 1ps
module tb_glm_categorical_score_top;
	import gcs_pkg::*;

	// Command code that the block must ignore.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [63:0] MASK_ALL = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MASK_NONE = 64'd0;
	localparam longint LOG2E_FIX = 64'd1549082005;
	localparam longint unsigned ROOT_FIX = 64'd1085434106;
	localparam longint unsigned SCORE_MAX = 64'hFFFF_FFFF_FFFF;
	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -64'sd549755813888;
	// Cycles in which nothing is accepted before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	// Quiet cycles granted to the block after the last result before a register write.
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic [1:0]         cmd;
		logic [5:0]         feature;
		logic [7:0]         level;
		logic [9:0]         cidx;
		logic signed [23:0] cval;
		logic [9:0]         oval;
		logic [31:0]        weight;
		logic signed [31:0] resp;
		logic [23:0]        sample;
		logic               last;
	} item_t;

	typedef struct {
		logic [31:0]        obs;
		logic [23:0]        sample;
		logic signed [31:0] resp;
		logic signed [31:0] lp;
		logic [47:0]        pred;
		logic [31:0]        weight;
		logic               err;
	} score_t;

	// A directed row; where typed is set, the listed result fields are checked
	// against the values written here instead of the predictor's.
	typedef struct {
		item_t              it;
		bit                 typed;
		logic signed [31:0] lp;
		logic [47:0]        pred;
		logic               err;
	} row_t;

	logic               clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [63:0]        cfg_wdata;
	logic [1:0]         cmd;
	logic [5:0]         feature;
	logic [7:0]         level;
	logic [9:0]         coeff_index, offset_value;
	logic signed [23:0] coeff_value;
	logic [31:0]        weight, weight_out, obs_number;
	logic signed [31:0] response, response_out, linear_predictor;
	logic [23:0]        sample_id, sample_out;
	logic               last, index_error;
	logic [47:0]        prediction;

	glm_categorical_score_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .feature(feature),
		.level(level), .coeff_index(coeff_index), .coeff_value(coeff_value),
		.offset_value(offset_value), .weight(weight), .response(response),
		.sample_id(sample_id), .last(last), .out_valid(out_valid),
		.out_ready(out_ready), .obs_number(obs_number), .sample_out(sample_out),
		.response_out(response_out), .linear_predictor(linear_predictor),
		.prediction(prediction), .weight_out(weight_out), .index_error(index_error)
	);

	// Shadow copy of the block's state, updated as each item is accepted.
	logic signed [23:0]  coeff_mem [0:1023];
	bit                  coeff_set [0:1023];
	logic [9:0]          offset_mem [0:63];
	bit                  offset_set [0:63];
	longint              acc;
	bit                  acc_err;
	logic [31:0]         scored;
	logic [63:0]         mask;
	longint unsigned     root_tab [0:64];

	score_t pending_scores[$];
	int     fails;
	int     send_idle, recv_stall;
	bit     hold_req;
	int     quiet;
	int     sent;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Q30 values of 2^(k/64), each step a rounded multiply by the 64th root of two.
	initial begin
		root_tab[0] = 64'd1 << 30;
		for (int k = 1; k <= 64; k++) begin
			root_tab[k] = (root_tab[k-1] * ROOT_FIX + (64'd1 << 29)) >> 30;
		end
	end

	// exp(lp) * w: lp is rescaled to log2 in Q16.16, the fractional power comes
	// from the table with linear interpolation, and the integer part is a shift.
	function automatic logic [47:0] exp_weighted(longint lp, logic [31:0] w);
		longint          t, n, s;
		longint unsigned u, e0, e1, m, p, r;
		int              i;
		t = (lp * LOG2E_FIX) >>> 30;
		n = t >>> 16;
		u = t - n * 65536;
		i = int'(u[15:10]);
		r = u & 64'd1023;
		e0 = root_tab[i];
		e1 = root_tab[i+1];
		m = e0 + (((e1 - e0) * r + 64'd512) >> 10);
		p = m * longint'(w);
		s = n - 30;
		if (p == 0)
			return '0;
		if (s >= 0) begin
			if (s >= 48 || p > (SCORE_MAX >> s))
				return SCORE_MAX[47:0];
			return 48'(p << s);
		end
		if (s <= -64)
			return '0;
		p = p >> (-s);
		return (p > SCORE_MAX) ? SCORE_MAX[47:0] : 48'(p);
	endfunction

	// Applies one accepted item to the shadow state; emitted is set when the
	// item closes an observation, and res then holds the expected result.
	task automatic score_item(input item_t it, output bit emitted, output score_t res);
		int     k;
		longint lp;
		emitted = 1'b0;
		res = '{default: '0};
		case (it.cmd)
			CMD_COEFF: begin
				coeff_mem[it.cidx] = it.cval;
				coeff_set[it.cidx] = 1'b1;
			end
			CMD_OFFSET: begin
				offset_mem[it.feature] = it.oval;
				offset_set[it.feature] = 1'b1;
			end
			CMD_LEVEL: begin
				if (mask[it.feature]) begin
					k = int'(offset_mem[it.feature]) + int'(it.level);
					if (k >= 1024) begin
						acc_err = 1'b1;
					end else begin
						acc = acc + longint'(coeff_mem[k]);
						if (acc > ACC_HI)
							acc = ACC_HI;
						if (acc < ACC_LO)
							acc = ACC_LO;
					end
				end
				if (it.last) begin
					lp = longint'(coeff_mem[0]) + acc;
					if (lp > 64'sd2147483647)
						lp = 64'sd2147483647;
					if (lp < -64'sd2147483648)
						lp = -64'sd2147483648;
					res.obs = scored;
					res.sample = it.sample;
					res.resp = it.resp;
					res.lp = 32'(lp);
					res.pred = exp_weighted(lp, it.weight);
					res.weight = it.weight;
					res.err = acc_err;
					emitted = 1'b1;
					scored = scored + 1;
					acc = 0;
					acc_err = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	// Offers one item and returns at the edge where it is accepted. A random gap
	// may come first; valid only drops when such a gap is taken.
	task automatic offer(input item_t it, output bit emitted, output score_t res);
		bit ok;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		feature <= it.feature;
		level <= it.level;
		coeff_index <= it.cidx;
		coeff_value <= it.cval;
		offset_value <= it.oval;
		weight <= it.weight;
		response <= it.resp;
		sample_id <= it.sample;
		last <= it.last;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		sent++;
		score_item(it, emitted, res);
	endtask

	task automatic send(input item_t it);
		bit     emitted;
		score_t res;
		offer(it, emitted, res);
		if (emitted)
			pending_scores.push_back(res);
	endtask

	// Holds the input side until every expected result has come back, then
	// gives the block time to finish any table write still in flight.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [63:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mask = v;
	endtask

	function automatic item_t noise_item();
		item_t it;
		it.cmd = 2'($urandom_range(3));
		it.feature = 6'($urandom);
		it.level = 8'($urandom);
		it.cidx = 10'($urandom);
		it.cval = 24'($urandom);
		it.oval = 10'($urandom);
		it.weight = $urandom;
		it.resp = $urandom;
		it.sample = 24'($urandom);
		it.last = 1'($urandom);
		return it;
	endfunction

	function automatic logic signed [23:0] pick_coeff();
		if ($urandom_range(1))
			return 24'($signed($urandom_range(262143)) - 131072);
		return 24'($urandom);
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(3))
			0: return '0;
			1: return $urandom_range(32'h0003_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// One level item on a feature whose offset is loaded. If every level tried
	// lands on an unloaded coefficient, that coefficient is written first so
	// that no unwritten entry is ever read.
	task automatic send_level(input bit is_last);
		item_t it;
		item_t wr;
		int    k;
		bit    good;
		it = noise_item();
		it.cmd = CMD_LEVEL;
		it.last = is_last;
		it.weight = pick_weight();
		do
			it.feature = 6'($urandom);
		while (!offset_set[it.feature]);
		good = 1'b0;
		for (int tries = 0; tries < 8 && !good; tries++) begin
			it.level = 8'($urandom);
			k = int'(offset_mem[it.feature]) + int'(it.level);
			good = (k >= 1024) || coeff_set[k];
		end
		if (!good) begin
			wr = noise_item();
			wr.cmd = CMD_COEFF;
			wr.cidx = 10'(k);
			wr.cval = pick_coeff();
			send(wr);
		end
		send(it);
	endtask

	// Random traffic: mostly whole observations, with table writes (some with a
	// stray last flag), unused commands and offset rewrites mixed in.
	task automatic random_phase(input int count);
		item_t it;
		int    stop;
		int    n;
		int    pick;
		stop = sent + count;
		while (sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				it = noise_item();
				it.cmd = CMD_COEFF;
				it.cval = pick_coeff();
				// Entries 1 and 1023 keep the extreme coefficients.
				if (it.cidx == 10'd1 || it.cidx == 10'd1023)
					it.cidx = 10'd2;
				send(it);
			end else if (pick < 16) begin
				it = noise_item();
				it.cmd = CMD_OFFSET;
				it.feature = 6'($urandom_range(1, 62));
				send(it);
			end else if (pick < 19) begin
				it = noise_item();
				it.cmd = CMD_UNUSED;
				send(it);
			end else begin
				n = $urandom_range(1, 6);
				for (int j = 1; j <= n; j++)
					send_level(j == n);
			end
		end
	endtask

	function automatic item_t mk(input logic [1:0] c, input logic [5:0] f,
			input logic [7:0] lv, input logic [9:0] ci, input logic signed [23:0] cv,
			input logic [9:0] ov, input logic [31:0] w, input logic l);
		item_t it;
		it.cmd = c;
		it.feature = f;
		it.level = lv;
		it.cidx = ci;
		it.cval = cv;
		it.oval = ov;
		it.weight = w;
		it.resp = 32'sh1234_5678;
		it.sample = 24'h00_0042;
		it.last = l;
		return it;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request so that a
	// result waits while items keep arriving and the input side backs up.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Result checker, sampled between edges where handshake signals are stable.
	always @(negedge clk) begin
		score_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_scores.size() == 0) begin
				$error("result with no expectation waiting, obs_number %0d", obs_number);
				fails++;
			end else begin
				e = pending_scores.pop_front();
				if (obs_number !== e.obs) begin
					$error("obs_number: expected %0d, got %0d", e.obs, obs_number);
					fails++;
				end
				if (sample_out !== e.sample) begin
					$error("sample_out: expected %h, got %h", e.sample, sample_out);
					fails++;
				end
				if (response_out !== e.resp) begin
					$error("response_out: expected %h, got %h", e.resp, response_out);
					fails++;
				end
				if (linear_predictor !== e.lp) begin
					$error("linear_predictor: expected %0d, got %0d", e.lp,
						linear_predictor);
					fails++;
				end
				if (prediction !== e.pred) begin
					$error("prediction: expected %h, got %h", e.pred, prediction);
					fails++;
				end
				if (weight_out !== e.weight) begin
					$error("weight_out: expected %h, got %h", e.weight, weight_out);
					fails++;
				end
				if (index_error !== e.err) begin
					$error("index_error: expected %b, got %b", e.err, index_error);
					fails++;
				end
			end
		end
	end

	// Watchdog: the run is hung if nothing moves on either channel for too long.
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		row_t   rows [$];
		bit     emitted;
		score_t res;
		item_t  it;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = '0;
		feature = '0;
		level = '0;
		coeff_index = '0;
		coeff_value = '0;
		offset_value = '0;
		weight = '0;
		response = '0;
		sample_id = '0;
		last = 1'b0;
		fails = 0;
		quiet = 0;
		sent = 0;
		hold_req = 1'b0;
		acc = 0;
		acc_err = 1'b0;
		scored = '0;
		mask = MASK_NONE;
		send_idle = 0;
		recv_stall = 0;
		foreach (coeff_set[i])
			coeff_set[i] = 1'b0;
		foreach (offset_set[i])
			offset_set[i] = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. The intercept is zero here, so the first results
		// can be read straight off: a zero weight gives a zero prediction and a
		// weight of one gives exactly one. Feature 63 points near the top of
		// the table so that its top level overruns it.
		rows.push_back('{mk(CMD_LEVEL, 6'd0, 8'd0, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b1),
			1'b0, 32'sd0, 48'd0, 1'b0});
		// With the mask still at its reset value of zero nothing adds; the
		// intercept must be loaded first, so this row is held back below.
		rows.delete();
		rows.push_back('{mk(CMD_COEFF, 6'd0, 8'd0, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b0),
			1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_OFFSET, 6'd0, 8'd0, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b0),
			1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_OFFSET, 6'd63, 8'd0, 10'd0, 24'sd0, 10'd1000, 32'd0, 1'b1),
			1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_COEFF, 6'd0, 8'd0, 10'd1, 24'sh7F_FFFF, 10'd0, 32'd0, 1'b0),
			1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_COEFF, 6'd0, 8'd0, 10'd1023, 24'sh80_0000, 10'd0, 32'd0,
			1'b1), 1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_COEFF, 6'd0, 8'd0, 10'd255, 24'sh01_0000, 10'd0, 32'd0,
			1'b0), 1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_COEFF, 6'd0, 8'd0, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b0),
			1'b0, 0, 0, 0});
		// Mask is zero: the level is ignored, the score is the zero intercept.
		rows.push_back('{mk(CMD_LEVEL, 6'd0, 8'd1, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b1),
			1'b1, 32'sd0, 48'd0, 1'b0});
		rows.push_back('{mk(CMD_LEVEL, 6'd63, 8'd255, 10'd0, 24'sd0, 10'd0, 32'h0001_0000,
			1'b1), 1'b1, 32'sd0, 48'h00_0001_0000, 1'b0});
		foreach (rows[r]) begin
			offer(rows[r].it, emitted, res);
			if (emitted) begin
				if (rows[r].typed) begin
					res.lp = rows[r].lp;
					res.pred = rows[r].pred;
					res.err = rows[r].err;
				end
				pending_scores.push_back(res);
			end
		end

		// Second directed block with every feature enabled.
		write_mask(MASK_ALL);
		rows.delete();
		rows.push_back('{mk(CMD_LEVEL, 6'd0, 8'd0, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b1),
			1'b1, 32'sd0, 48'd0, 1'b0});
		rows.push_back('{mk(CMD_LEVEL, 6'd0, 8'd0, 10'd0, 24'sd0, 10'd0, 32'h0001_0000,
			1'b1), 1'b1, 32'sd0, 48'h00_0001_0000, 1'b0});
		// Offset 1000 plus level 255 runs past the table: flag set, nothing added.
		rows.push_back('{mk(CMD_LEVEL, 6'd63, 8'd255, 10'd0, 24'sd0, 10'd0, 32'h0001_0000,
			1'b1), 1'b1, 32'sd0, 48'h00_0001_0000, 1'b1});
		// The most negative and most positive coefficients in one observation.
		rows.push_back('{mk(CMD_LEVEL, 6'd63, 8'd23, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b0),
			1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_LEVEL, 6'd0, 8'd1, 10'd0, 24'sd0, 10'd0, 32'hFFFF_FFFF,
			1'b1), 1'b0, 0, 0, 0});
		// An unused command carrying last must not close the observation.
		rows.push_back('{mk(CMD_UNUSED, 6'd0, 8'd1, 10'd0, 24'sd0, 10'd0, 32'd0, 1'b1),
			1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_COEFF, 6'd0, 8'd0, 10'd2, 24'sd5, 10'd0, 32'd0, 1'b1),
			1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_LEVEL, 6'd0, 8'd255, 10'd0, 24'sd0, 10'd0, 32'hFFFF_FFFF,
			1'b1), 1'b0, 0, 0, 0});
		rows.push_back('{mk(CMD_LEVEL, 6'd0, 8'd2, 10'd0, 24'sd0, 10'd0, 32'h8000_0000,
			1'b1), 1'b0, 0, 0, 0});
		foreach (rows[r]) begin
			offer(rows[r].it, emitted, res);
			if (emitted) begin
				if (rows[r].typed) begin
					res.lp = rows[r].lp;
					res.pred = rows[r].pred;
					res.err = rows[r].err;
				end
				pending_scores.push_back(res);
			end
		end

		// Long observations that drive the predictor into both saturation limits.
		for (int j = 0; j < 260; j++) begin
			it = mk(CMD_LEVEL, 6'd0, 8'd1, 10'd0, 24'sd0, 10'd0, 32'h0001_0000, j == 259);
			send(it);
		end
		for (int j = 0; j < 260; j++) begin
			it = mk(CMD_LEVEL, 6'd63, 8'd23, 10'd0, 24'sd0, 10'd0, 32'hFFFF_FFFF, j == 259);
			send(it);
		end

		// Phase one: the sender idles often, the receiver stalls most of the time.
		write_mask({$urandom, $urandom});
		send_idle = 38;
		recv_stall = 79;
		random_phase(220);

		// Phase two: the roles swap, with no feature enabled.
		write_mask(MASK_NONE);
		send_idle = 79;
		recv_stall = 38;
		random_phase(220);

		// Phase three: full rate on both sides, with one long receiver hold-off
		// while the sender keeps pushing items.
		write_mask({$urandom, $urandom} | 64'h8000_0000_0000_0001);
		send_idle = 0;
		recv_stall = 0;
		hold_req = 1'b1;
		random_phase(220);

		drain();
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_tables.sv
hw/rtl/gcs_exp.sv
hw/rtl/glm_categorical_score_top.sv
verif/tb_glm_categorical_score_top.sv
